// ----- hdl/ngps_pkg.sv -----
// Shared types and constants for the nearest grid point search block.
// No dependencies; every other file imports this package.
package ngps_pkg;

   localparam int MAX_ROWS_DEFAULT   = 32;
   localparam int MAX_COLS_DEFAULT   = 32;
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int CELL_COUNT_DEFAULT = 4;

   // Register port geometry: two registers, byte addresses 0 and 4
   localparam int DIM_W      = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic {
      REG_GRID_ROWS = 1'b0,
      REG_GRID_COLS = 1'b1
   } reg_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIVIDE,
      ST_OUT
   } state_type;

   // Per-cell strobes from the sequencer
   typedef struct packed {
      logic write;
      logic step;
      logic clear;
   } cell_ctrl_type;

   function automatic int width_of(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ----- hdl/ngps_cell.sv -----
// One search cell: a bank of stored points, a distance pipeline, a local minimum
// and one link of the merge chain. Depends on ngps_pkg.
module ngps_cell
   import ngps_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int BANK_DEPTH = 256,
   parameter int ADDR_W     = 8,
   parameter int SLOT_W     = 10,
   parameter int BASE_W     = 11,
   parameter int CNT_W      = 11,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  logic [ADDR_W-1:0]            rd_addr,
   input  logic [BASE_W-1:0]            base,
   input  logic [CNT_W-1:0]             count,
   input  logic signed [COORD_BITS-1:0] query_x,
   input  logic signed [COORD_BITS-1:0] query_y,
   input  logic                         prev_found,
   input  logic [2*COORD_BITS:0]        prev_dist,
   input  logic [SLOT_W-1:0]            prev_slot,
   output logic                         next_found,
   output logic [2*COORD_BITS:0]        next_dist,
   output logic [SLOT_W-1:0]            next_slot
);

   localparam int WORD_W = 2 * COORD_BITS;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int DIST_W = 2 * COORD_BITS + 1;

   logic [WORD_W-1:0] mem [BANK_DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   logic [BASE_W-1:0] slot_wide;
   logic              live;

   logic              valid_s1_ff, valid_s2_ff, valid_s3_ff;
   logic [SLOT_W-1:0] slot_s1_ff, slot_s2_ff, slot_s3_ff;

   logic signed [DIFF_W-1:0]   dx_in, dy_in, dx_ff, dy_ff;
   logic signed [2*DIFF_W-1:0] prod_x, prod_y;
   logic [SQ_W-1:0]            sqx_ff, sqy_ff;
   logic [DIST_W-1:0]          dist_now;

   logic              local_found_ff;
   logic [DIST_W-1:0] local_dist_ff;
   logic [SLOT_W-1:0] local_slot_ff;
   logic              take_local;

   logic              next_found_ff;
   logic [DIST_W-1:0] next_dist_ff;
   logic [SLOT_W-1:0] next_slot_ff;

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         mem[wr_addr] <= {wr_x, wr_y};
      end
      if (ctrl.step) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   // Entries past the current grid size are skipped
   assign slot_wide = base + BASE_W'(CELL_INDEX);
   assign live      = ctrl.step && (slot_wide < BASE_W'(count));

   assign dx_in = {rd_word_ff[WORD_W-1], rd_word_ff[WORD_W-1:COORD_BITS]}
                - {query_x[COORD_BITS-1], query_x};
   assign dy_in = {rd_word_ff[COORD_BITS-1], rd_word_ff[COORD_BITS-1:0]}
                - {query_y[COORD_BITS-1], query_y};

   assign prod_x   = dx_ff * dx_ff;
   assign prod_y   = dy_ff * dy_ff;
   assign dist_now = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
      end else begin
         valid_s1_ff <= live;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
      end
      slot_s1_ff <= slot_wide[SLOT_W-1:0];
      slot_s2_ff <= slot_s1_ff;
      slot_s3_ff <= slot_s2_ff;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sqx_ff     <= prod_x[SQ_W-1:0];
      sqy_ff     <= prod_y[SQ_W-1:0];
   end

   // Strict compare keeps the earliest slot of this bank on a tie
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         local_found_ff <= 1'b0;
      end else if (valid_s3_ff && (!local_found_ff || dist_now < local_dist_ff)) begin
         local_found_ff <= 1'b1;
      end
      if (valid_s3_ff && (!local_found_ff || dist_now < local_dist_ff)) begin
         local_dist_ff <= dist_now;
         local_slot_ff <= slot_s3_ff;
      end
   end

   // Banks interleave slots, so a tie across cells falls back on the slot number
   assign take_local = local_found_ff &&
                       (!prev_found || local_dist_ff < prev_dist ||
                        (local_dist_ff == prev_dist && local_slot_ff < prev_slot));

   always_ff @(posedge clock) begin
      if (reset) begin
         next_found_ff <= 1'b0;
      end else begin
         next_found_ff <= prev_found || local_found_ff;
      end
      next_dist_ff <= take_local ? local_dist_ff : prev_dist;
      next_slot_ff <= take_local ? local_slot_ff : prev_slot;
   end

   assign next_found = next_found_ff;
   assign next_dist  = next_dist_ff;
   assign next_slot  = next_slot_ff;

endmodule

// ----- hdl/nearest_grid_point_search.sv -----
// Top level of the nearest grid point search: sequencer, register port,
// chain of search cells and row/column divider. Depends on ngps_pkg, ngps_cell.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_func, req_point_x, req_point_y
//   rsp       out        rsp_valid/rsp_stall  rsp_near_row, rsp_near_col, rsp_dist_sq
//   register  in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A load beat gives no result. For a query beat the banks are scanned one entry
// per cell per cycle, the cell minima merge down the chain, then row and column
// come out of a one-bit-per-cycle restoring divider.
// Reset sets both dimensions to 1 and the write pointer to 0; stored points are
// undefined until loaded and no clearing pass runs.
// A finished result waits in the output register; new beats are taken meanwhile,
// but a following query holds before its result until that register is free.
module nearest_grid_point_search
   import ngps_pkg::*;
#(
   parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS   = MAX_COLS_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int CELL_COUNT = CELL_COUNT_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_func,
   input  logic signed [COORD_BITS-1:0]            req_point_x,
   input  logic signed [COORD_BITS-1:0]            req_point_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [width_of(MAX_ROWS)-1:0]           rsp_near_row,
   output logic [width_of(MAX_COLS)-1:0]           rsp_near_col,
   output logic [2*COORD_BITS:0]                   rsp_dist_sq,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [CSR_ADDR_W-1:0]                   paddr,
   input  logic [CSR_DATA_W-1:0]                   pwdata,
   output logic [CSR_DATA_W-1:0]                   prdata,
   output logic                                    pready
);

   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int SLOT_W      = width_of(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int BANK_DEPTH  = (STORE_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
   localparam int ADDR_W      = width_of(BANK_DEPTH);
   localparam int BASE_W      = $clog2(STORE_DEPTH + CELL_COUNT + 1);
   localparam int CELL_W      = width_of(CELL_COUNT);
   localparam int ROW_W       = width_of(MAX_ROWS);
   localparam int COL_W       = width_of(MAX_COLS);
   localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
   localparam int COLS_W      = $clog2(MAX_COLS + 1);
   localparam int DIST_W      = 2 * COORD_BITS + 1;
   // three cell pipeline stages after the read, then one register per chain link
   localparam int DRAIN_LEN   = CELL_COUNT + 3;
   localparam int DRAIN_W     = $clog2(DRAIN_LEN + 1);
   localparam int DIV_W       = $clog2(SLOT_W + 1);

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0] grid_rows_ff, grid_cols_ff;
   logic             csr_write;
   reg_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= DIM_W'(1);
         grid_cols_ff <= DIM_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GRID_ROWS: grid_rows_ff <= pwdata[DIM_W-1:0];
            REG_GRID_COLS: grid_cols_ff <= pwdata[DIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GRID_ROWS: prdata = CSR_DATA_W'(grid_rows_ff);
         REG_GRID_COLS: prdata = CSR_DATA_W'(grid_cols_ff);
      endcase
   end

   // Zero counts as one, anything above the maximum as the maximum
   logic [ROWS_W-1:0] rows_eff;
   logic [COLS_W-1:0] cols_eff;
   logic [CNT_W-1:0]  count_eff;

   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (int'(grid_rows_ff) > MAX_ROWS) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_W'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (int'(grid_cols_ff) > MAX_COLS) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(grid_cols_ff);
      end
   end

   assign count_eff = CNT_W'(rows_eff) * CNT_W'(cols_eff);

   // ---------------------------------------------------------------- sequencer
   state_type state_ff, state_in;

   logic req_take, load_take, query_take;
   logic scan_last, drain_done, div_last, out_free;

   logic [BASE_W-1:0]  base_ff, base_in, base_next;
   logic [ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic [DRAIN_W-1:0] drain_cnt_ff, drain_cnt_in;
   logic [DIV_W-1:0]   div_cnt_ff, div_cnt_in;

   assign req_take   = req_valid && !req_stall;
   assign load_take  = req_take && (func_type'(req_func) == FUNC_LOAD);
   assign query_take = req_take && (func_type'(req_func) == FUNC_QUERY);
   assign base_next  = base_ff + BASE_W'(CELL_COUNT);
   assign scan_last  = base_next >= BASE_W'(count_eff);
   assign drain_done = drain_cnt_ff == '0;
   assign div_last   = div_cnt_ff == DIV_W'(1);
   assign out_free   = !rsp_valid || !rsp_stall;

   logic               chain_found [CELL_COUNT+1];
   logic [DIST_W-1:0]  chain_dist  [CELL_COUNT+1];
   logic [SLOT_W-1:0]  chain_slot  [CELL_COUNT+1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (query_take) state_in = ST_SCAN;
         ST_SCAN:   if (scan_last) state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = chain_found[CELL_COUNT] ? ST_DIVIDE : ST_IDLE;
            end
         end
         ST_DIVIDE: if (div_last) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs of the sequencer
   always_comb begin
      req_stall    = 1'b1;
      base_in      = base_ff;
      scan_addr_in = scan_addr_ff;
      drain_cnt_in = drain_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            base_in      = '0;
            scan_addr_in = '0;
         end
         ST_SCAN: begin
            base_in      = base_next;
            scan_addr_in = scan_addr_ff + ADDR_W'(1);
            drain_cnt_in = DRAIN_W'(DRAIN_LEN);
         end
         ST_DRAIN: begin
            drain_cnt_in = drain_cnt_ff - DRAIN_W'(1);
            div_cnt_in   = DIV_W'(SLOT_W);
         end
         ST_DIVIDE: div_cnt_in = div_cnt_ff - DIV_W'(1);
         ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      scan_addr_ff <= scan_addr_in;
      drain_cnt_ff <= drain_cnt_in;
      div_cnt_ff   <= div_cnt_in;
   end

   // ---------------------------------------------------------------- write pointer
   logic [SLOT_W-1:0] load_slot_ff, load_slot_in;
   logic [CELL_W-1:0] load_cell_ff, load_cell_in;
   logic [ADDR_W-1:0] load_addr_ff, load_addr_in;
   logic [SLOT_W-1:0] wr_slot;
   logic [CELL_W-1:0] wr_cell;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_slot_next;
   logic              ptr_stale;

   // Grid shrunk under the pointer: drop back to entry zero
   assign ptr_stale    = CNT_W'(load_slot_ff) >= count_eff;
   assign wr_slot      = ptr_stale ? '0 : load_slot_ff;
   assign wr_cell      = ptr_stale ? '0 : load_cell_ff;
   assign wr_addr      = ptr_stale ? '0 : load_addr_ff;
   assign wr_slot_next = CNT_W'(wr_slot) + CNT_W'(1);

   always_comb begin
      load_slot_in = load_slot_ff;
      load_cell_in = load_cell_ff;
      load_addr_in = load_addr_ff;
      if (load_take) begin
         if (wr_slot_next >= count_eff) begin
            load_slot_in = '0;
            load_cell_in = '0;
            load_addr_in = '0;
         end else begin
            load_slot_in = wr_slot_next[SLOT_W-1:0];
            if (wr_cell == CELL_W'(CELL_COUNT - 1)) begin
               load_cell_in = '0;
               load_addr_in = wr_addr + ADDR_W'(1);
            end else begin
               load_cell_in = wr_cell + CELL_W'(1);
               load_addr_in = wr_addr;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_slot_ff <= '0;
         load_cell_ff <= '0;
         load_addr_ff <= '0;
      end else begin
         load_slot_ff <= load_slot_in;
         load_cell_ff <= load_cell_in;
         load_addr_ff <= load_addr_in;
      end
   end

   // ---------------------------------------------------------------- query point
   logic signed [COORD_BITS-1:0] query_x_ff, query_y_ff;

   always_ff @(posedge clock) begin
      if (query_take) begin
         query_x_ff <= req_point_x;
         query_y_ff <= req_point_y;
      end
   end

   // ---------------------------------------------------------------- cell chain
   // The head of the chain sees no candidate; each link passes its merged best on
   cell_ctrl_type cell_ctrl [CELL_COUNT];

   assign chain_found[0] = 1'b0;
   assign chain_dist[0]  = '0;
   assign chain_slot[0]  = '0;

   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      assign cell_ctrl[c].write = load_take && (wr_cell == CELL_W'(c));
      assign cell_ctrl[c].step  = state_ff == ST_SCAN;
      assign cell_ctrl[c].clear = query_take;

      ngps_cell #(
         .COORD_BITS (COORD_BITS),
         .BANK_DEPTH (BANK_DEPTH),
         .ADDR_W     (ADDR_W),
         .SLOT_W     (SLOT_W),
         .BASE_W     (BASE_W),
         .CNT_W      (CNT_W),
         .CELL_INDEX (c)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[c]),
         .wr_addr    (wr_addr),
         .wr_x       (req_point_x),
         .wr_y       (req_point_y),
         .rd_addr    (scan_addr_ff),
         .base       (base_ff),
         .count      (count_eff),
         .query_x    (query_x_ff),
         .query_y    (query_y_ff),
         .prev_found (chain_found[c]),
         .prev_dist  (chain_dist[c]),
         .prev_slot  (chain_slot[c]),
         .next_found (chain_found[c+1]),
         .next_dist  (chain_dist[c+1]),
         .next_slot  (chain_slot[c+1])
      );
   end

   // ---------------------------------------------------------------- divider
   // Restoring division of the winning slot by the column count: the dividend
   // register fills with quotient bits from the bottom, the remainder is the column.
   logic [SLOT_W-1:0] div_num_ff, div_num_in;
   logic [COLS_W-1:0] rem_ff, rem_in;
   logic [COLS_W:0]   rem_shift, rem_sub;
   logic              rem_fits;
   logic [DIST_W-1:0] best_dist_ff;

   assign rem_shift = {rem_ff, div_num_ff[SLOT_W-1]};
   assign rem_sub   = rem_shift - (COLS_W+1)'(cols_eff);
   assign rem_fits  = rem_shift >= (COLS_W+1)'(cols_eff);

   always_comb begin
      div_num_in = div_num_ff;
      rem_in     = rem_ff;
      unique case (state_ff)
         ST_DRAIN: begin
            div_num_in = chain_slot[CELL_COUNT];
            rem_in     = '0;
         end
         ST_DIVIDE: begin
            div_num_in = {div_num_ff[SLOT_W-1:0] << 1} | SLOT_W'(rem_fits);
            rem_in     = rem_fits ? rem_sub[COLS_W-1:0] : rem_shift[COLS_W-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      rem_ff     <= rem_in;
      if (state_ff == ST_DRAIN) begin
         best_dist_ff <= chain_dist[CELL_COUNT];
      end
   end

   // ---------------------------------------------------------------- result register
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_load;

   assign rsp_load = (state_ff == ST_OUT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_row_ff  <= div_num_ff[ROW_W-1:0];
         rsp_col_ff  <= rem_ff[COL_W-1:0];
         rsp_dist_ff <= best_dist_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_near_row = rsp_row_ff;
   assign rsp_near_col = rsp_col_ff;
   assign rsp_dist_sq  = rsp_dist_ff;

   // ---------------------------------------------------------------- checks
   // a query beat always starts a scan
   a_query_scans: assert property (@(posedge clock) disable iff (reset)
      query_take |=> state_ff == ST_SCAN)
      else $error("query beat did not start a scan");

   // the pointer's bank and row track its slot number
   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      int'(load_addr_ff) * CELL_COUNT + int'(load_cell_ff) == int'(load_slot_ff))
      else $error("write pointer bank/address out of step with slot");

   // the remainder left by the divider is a valid column
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> rem_ff < cols_eff)
      else $error("column remainder not below column count");

   // no result is loaded while the previous one is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !rsp_load)
      else $error("result register overwritten while stalled");

endmodule
